// ===== design/dpp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_pkg
// Shared types and constants of the derivation path parser: parse phases,
// path type codes, character codes and the per-level record.
// ----------------------------------------------------------------------------
package dpp_pkg;

    // Parser phases.
    typedef enum logic [2:0] {
        PH_EXPECT_M,
        PH_AFTER_M,
        PH_IN_SEG,
        PH_AFTER_MARK,
        PH_DEAD
    } t_phase;

    // Path type codes held in the configuration register.
    localparam logic [3:0] PT_ROOT    = 4'd0;
    localparam logic [3:0] PT_BIP32   = 4'd1;
    localparam logic [3:0] PT_BIP44   = 4'd2;
    localparam logic [3:0] PT_BIP49   = 4'd3;
    localparam logic [3:0] PT_BIP54   = 4'd4;
    localparam logic [3:0] PT_BIP74   = 4'd5;
    localparam logic [3:0] PT_BIP84   = 4'd6;
    localparam logic [3:0] PT_BIP86   = 4'd7;
    localparam logic [3:0] PT_SLIP10  = 4'd8;
    localparam logic [3:0] PT_CIP11   = 4'd9;
    localparam logic [3:0] PT_CIP1852 = 4'd10;
    localparam logic [3:0] PT_ZIP32   = 4'd11;

    // Character codes.
    localparam logic [7:0] CH_M      = 8'h6D;
    localparam logic [7:0] CH_SLASH  = 8'h2F;
    localparam logic [7:0] CH_ZERO   = 8'h30;
    localparam logic [7:0] CH_NINE   = 8'h39;
    localparam logic [7:0] CH_APOS   = 8'h27;
    localparam logic [7:0] CH_LOW_H  = 8'h68;
    localparam logic [7:0] CH_HIGH_H = 8'h48;

    // Fixed purpose and coin values.
    localparam logic [31:0] PURPOSE_44   = 32'd44;
    localparam logic [31:0] PURPOSE_49   = 32'd49;
    localparam logic [31:0] PURPOSE_54   = 32'd54;
    localparam logic [31:0] PURPOSE_74   = 32'd74;
    localparam logic [31:0] PURPOSE_84   = 32'd84;
    localparam logic [31:0] PURPOSE_86   = 32'd86;
    localparam logic [31:0] PURPOSE_1852 = 32'd1852;
    localparam logic [31:0] PURPOSE_32   = 32'd32;
    localparam logic [31:0] COIN_ADA     = 32'd1815;
    localparam logic [31:0] COIN_ATOM    = 32'd118;
    localparam logic [31:0] COIN_ZEC     = 32'd133;

    // Number of levels kept for the type rules.
    localparam int STORED_LEVELS = 5;

    // One stored level: index value and hardening mark.
    typedef struct packed {
        logic        hard;
        logic [31:0] value;
    } t_level;

    // Level count facts needed by the type rules.
    typedef struct packed {
        logic is3;
        logic is4;
        logic is5;
        logic ge1;
    } t_count_info;

    // Checked result without the level count.
    typedef struct packed {
        logic        path_valid;
        logic [31:0] coin_value;
        logic [31:0] account_value;
        logic [31:0] charge_value;
        logic [31:0] leaf_index;
        logic        leaf_hardened;
        logic        leaf_present;
    } t_result;

    // Purpose level expected by each member of the bip44 family.
    function automatic logic [31:0] family_purpose(input logic [3:0] ptype);
        logic [31:0] p;
        unique case (ptype)
            PT_BIP44: p = PURPOSE_44;
            PT_BIP49: p = PURPOSE_49;
            PT_BIP54: p = PURPOSE_54;
            PT_BIP74: p = PURPOSE_74;
            PT_BIP84: p = PURPOSE_84;
            default:  p = PURPOSE_86;
        endcase
        return p;
    endfunction

endpackage

// ===== design/derivation_path_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// derivation_path_parser
// Parses a derivation path one character per transaction and reports one
// checked result per path.
// ----------------------------------------------------------------------------
// Throughput: one input transaction per cycle while the skid register is empty
//   (o_s_tready high); the parser state updates in the cycle a character is accepted.
// The result of the final transaction is registered and presented on o_m_tvalid.
// A two-entry output buffer lets input continue while a result waits.
// Reset (synchronous, i_rst_n low) rearms the parser, sets path_type to root
//   and empties the output buffer.
// ----------------------------------------------------------------------------
module derivation_path_parser #(
    parameter int MAX_LEVEL_COUNT = 255
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    // Configuration: path_type register.
    input  logic         i_cfg_we,
    input  logic [3:0]   i_cfg_wdata,
    // Input stream.
    input  logic         i_s_tvalid,
    output logic         o_s_tready,
    input  logic [7:0]   i_s_tdata,   // [7:0] char_code
    input  logic         i_s_tlast,   // last_char
    input  logic         i_s_tuser,   // empty_path
    // Result stream.
    output logic         o_m_tvalid,
    input  logic         i_m_tready,
    // [0] path_valid, [8:1] level_total, [40:9] coin_value,
    // [72:41] account_value, [104:73] charge_value, [136:105] leaf_index,
    // [137] leaf_hardened, [138] leaf_present, [143:139] zero
    output logic [143:0] o_m_tdata
);

    localparam int CNT_W = $clog2(MAX_LEVEL_COUNT + 1);
    localparam int EXT_W = (CNT_W > 8) ? CNT_W : 8;
    localparam int IDX_W = $clog2(dpp_pkg::STORED_LEVELS);

    // Parser state.
    logic [3:0]       r_path_type;
    dpp_pkg::t_phase  r_phase, n_phase;
    logic [31:0]      r_value, n_value;
    logic             r_digits, n_digits;
    logic             r_mark, n_mark;
    logic             r_ovf, n_ovf;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic             r_err, n_err;
    dpp_pkg::t_level  r_store [dpp_pkg::STORED_LEVELS];

    // Working values for one transaction.
    logic             in_fire;
    logic             final_item;
    logic [7:0]       ch;
    logic             is_digit;
    logic             is_mark;
    logic [35:0]      mac;
    logic             st_we;
    logic [IDX_W-1:0] st_idx;
    dpp_pkg::t_level  st_data;
    logic             path_empty;
    logic             parse_ok;
    dpp_pkg::t_level  eff_levels [dpp_pkg::STORED_LEVELS];
    dpp_pkg::t_count_info cnt_info;
    dpp_pkg::t_result eval_res;
    logic [EXT_W-1:0] cnt_ext;
    logic [7:0]       level_total;
    logic [143:0]     res_word;

    // Output buffer.
    logic             r_out_valid;
    logic [143:0]     r_out_data;
    logic             r_skid_valid;
    logic [143:0]     r_skid_data;
    logic             out_fire;
    logic             res_we;

    assign o_s_tready = ~r_skid_valid;
    assign in_fire    = i_s_tvalid & ~r_skid_valid;
    assign final_item = i_s_tuser | i_s_tlast;
    assign ch         = i_s_tdata;
    assign is_digit   = (ch >= dpp_pkg::CH_ZERO) && (ch <= dpp_pkg::CH_NINE);
    assign is_mark    = (ch == dpp_pkg::CH_APOS) || (ch == dpp_pkg::CH_LOW_H)
                        || (ch == dpp_pkg::CH_HIGH_H);
    // Decimal step: value * 10 + digit.
    assign mac = {1'b0, r_value, 3'b000} + {3'b000, r_value, 1'b0}
                 + {28'd0, ch - dpp_pkg::CH_ZERO};

    // Character step, then the closing of an open segment on a final item.
    always_comb begin
        n_phase  = r_phase;
        n_value  = r_value;
        n_digits = r_digits;
        n_mark   = r_mark;
        n_ovf    = r_ovf;
        n_cnt    = r_cnt;
        n_err    = r_err;
        st_we    = 1'b0;
        st_idx   = r_cnt[IDX_W-1:0];
        st_data  = '{hard: r_mark, value: r_value};

        if (!i_s_tuser) begin
            unique case (r_phase)
                dpp_pkg::PH_EXPECT_M: begin
                    if (ch == dpp_pkg::CH_M) begin
                        n_phase = dpp_pkg::PH_AFTER_M;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = dpp_pkg::PH_DEAD;
                    end
                end
                dpp_pkg::PH_AFTER_M: begin
                    if (ch == dpp_pkg::CH_SLASH) begin
                        n_phase = dpp_pkg::PH_IN_SEG;
                    end else begin
                        n_err   = 1'b1;
                        n_phase = dpp_pkg::PH_DEAD;
                    end
                end
                dpp_pkg::PH_IN_SEG, dpp_pkg::PH_AFTER_MARK: begin
                    if (r_phase == dpp_pkg::PH_IN_SEG && is_digit) begin
                        if (mac[35:32] != 4'd0) begin
                            n_ovf   = 1'b1;
                            n_err   = 1'b1;
                            n_phase = dpp_pkg::PH_DEAD;
                        end else begin
                            n_value  = mac[31:0];
                            n_digits = 1'b1;
                        end
                    end else if (r_phase == dpp_pkg::PH_IN_SEG && is_mark) begin
                        if (!r_digits) begin
                            n_err   = 1'b1;
                            n_phase = dpp_pkg::PH_DEAD;
                        end else begin
                            n_mark  = 1'b1;
                            n_phase = dpp_pkg::PH_AFTER_MARK;
                        end
                    end else if (ch == dpp_pkg::CH_SLASH) begin
                        // Segment close on a slash.
                        if (!r_digits || r_ovf) begin
                            n_err   = 1'b1;
                            n_phase = dpp_pkg::PH_DEAD;
                        end else begin
                            if (r_cnt < CNT_W'(dpp_pkg::STORED_LEVELS)) begin
                                st_we   = 1'b1;
                                st_idx  = r_cnt[IDX_W-1:0];
                                st_data = '{hard: r_mark, value: r_value};
                            end
                            if (r_cnt >= CNT_W'(MAX_LEVEL_COUNT)) begin
                                n_err = 1'b1;
                            end else begin
                                n_cnt = r_cnt + CNT_W'(1);
                            end
                            n_value  = '0;
                            n_digits = 1'b0;
                            n_mark   = 1'b0;
                            n_ovf    = 1'b0;
                            if (!n_err) begin
                                n_phase = dpp_pkg::PH_IN_SEG;
                            end
                        end
                    end else begin
                        n_err   = 1'b1;
                        n_phase = dpp_pkg::PH_DEAD;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end

        // A path that never started counts as empty.
        path_empty = (n_phase == dpp_pkg::PH_EXPECT_M) && !n_err;

        // Final close of an open segment.
        if (final_item && (n_phase == dpp_pkg::PH_IN_SEG
                           || n_phase == dpp_pkg::PH_AFTER_MARK)) begin
            if (!n_digits || n_ovf) begin
                n_err   = 1'b1;
                n_phase = dpp_pkg::PH_DEAD;
            end else begin
                if (n_cnt < CNT_W'(dpp_pkg::STORED_LEVELS)) begin
                    st_we   = 1'b1;
                    st_idx  = n_cnt[IDX_W-1:0];
                    st_data = '{hard: n_mark, value: n_value};
                end
                if (n_cnt >= CNT_W'(MAX_LEVEL_COUNT)) begin
                    n_err = 1'b1;
                end else begin
                    n_cnt = n_cnt + CNT_W'(1);
                end
            end
        end

        parse_ok = !n_err && (n_phase != dpp_pkg::PH_DEAD);
    end

    // Levels as seen by the type rules, with this transaction's write merged.
    always_comb begin
        for (int k = 0; k < dpp_pkg::STORED_LEVELS; k++) begin
            eff_levels[k] = (st_we && st_idx == IDX_W'(k)) ? st_data : r_store[k];
        end
    end

    assign cnt_info.is3 = (n_cnt == CNT_W'(3));
    assign cnt_info.is4 = (n_cnt == CNT_W'(4));
    assign cnt_info.is5 = (n_cnt == CNT_W'(5));
    assign cnt_info.ge1 = (n_cnt != '0);

    dpp_eval u_eval (
        .i_path_type (r_path_type),
        .i_parse_ok  (parse_ok),
        .i_empty     (path_empty),
        .i_count     (cnt_info),
        .i_levels    (eff_levels),
        .o_result    (eval_res)
    );

    // Level count saturated to the reported width.
    assign cnt_ext     = EXT_W'(n_cnt);
    assign level_total = (cnt_ext > EXT_W'(255)) ? 8'hFF : cnt_ext[7:0];

    assign res_word = {5'd0,
                       eval_res.leaf_present,
                       eval_res.leaf_hardened,
                       eval_res.leaf_index,
                       eval_res.charge_value,
                       eval_res.account_value,
                       eval_res.coin_value,
                       level_total,
                       eval_res.path_valid};

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_path_type <= dpp_pkg::PT_ROOT;
        end else if (i_cfg_we) begin
            r_path_type <= i_cfg_wdata;
        end
    end

    // Parser state registers; a final transaction rearms the parser.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase  <= dpp_pkg::PH_EXPECT_M;
            r_value  <= '0;
            r_digits <= 1'b0;
            r_mark   <= 1'b0;
            r_ovf    <= 1'b0;
            r_cnt    <= '0;
            r_err    <= 1'b0;
        end else if (in_fire) begin
            if (final_item) begin
                r_phase  <= dpp_pkg::PH_EXPECT_M;
                r_value  <= '0;
                r_digits <= 1'b0;
                r_mark   <= 1'b0;
                r_ovf    <= 1'b0;
                r_cnt    <= '0;
                r_err    <= 1'b0;
            end else begin
                r_phase  <= n_phase;
                r_value  <= n_value;
                r_digits <= n_digits;
                r_mark   <= n_mark;
                r_ovf    <= n_ovf;
                r_cnt    <= n_cnt;
                r_err    <= n_err;
            end
        end
    end

    // Level store; entries are only read after being written for this path.
    always_ff @(posedge i_clk) begin
        if (in_fire && st_we) begin
            r_store[st_idx] <= st_data;
        end
    end

    // Two-entry output buffer: output register plus skid register.
    assign out_fire = r_out_valid & i_m_tready;
    assign res_we   = in_fire & final_item;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            if (!r_out_valid) begin
                r_out_valid <= res_we;
            end else if (out_fire) begin
                if (r_skid_valid) begin
                    r_skid_valid <= 1'b0;
                end else begin
                    r_out_valid <= res_we;
                end
            end else if (res_we) begin
                r_skid_valid <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!r_out_valid || (out_fire && !r_skid_valid)) begin
            if (res_we) begin
                r_out_data <= res_word;
            end
        end else if (out_fire) begin
            r_out_data <= r_skid_data;
        end
        if (r_out_valid && !out_fire && res_we) begin
            r_skid_data <= res_word;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

endmodule

// ===== design/dpp_eval.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dpp_eval
// Applies the rules of the configured path type to the parsed levels and
// forms the reported fields. Purely combinational.
// ----------------------------------------------------------------------------
module dpp_eval (
    input  logic [3:0]           i_path_type,
    input  logic                 i_parse_ok,
    input  logic                 i_empty,
    input  dpp_pkg::t_count_info i_count,
    input  dpp_pkg::t_level      i_levels [dpp_pkg::STORED_LEVELS],
    output dpp_pkg::t_result     o_result
);

    logic        ok;
    logic [31:0] coin;
    logic [31:0] acc;
    logic [31:0] chg;
    logic [31:0] idx;
    logic        hard;
    logic        pres;
    logic [31:0] cip_purpose;
    logic [31:0] cip_coin;

    assign cip_purpose = (i_path_type == dpp_pkg::PT_CIP11) ? dpp_pkg::PURPOSE_44
                                                            : dpp_pkg::PURPOSE_1852;
    assign cip_coin    = (i_path_type == dpp_pkg::PT_CIP11) ? dpp_pkg::COIN_ATOM
                                                            : dpp_pkg::COIN_ADA;

    // Type rules; any failure clears every field but the count.
    always_comb begin
        ok   = 1'b0;
        coin = '0;
        acc  = '0;
        chg  = '0;
        idx  = '0;
        hard = 1'b0;
        pres = 1'b0;
        if (i_path_type == dpp_pkg::PT_ROOT) begin
            ok = i_empty;
        end else if (i_parse_ok && !i_empty) begin
            unique case (i_path_type)
                dpp_pkg::PT_BIP32: begin
                    ok = i_count.is3 && i_levels[0].hard && !i_levels[1].hard
                         && (i_levels[1].value <= 32'd1);
                    acc  = i_levels[0].value;
                    chg  = i_levels[1].value;
                    idx  = i_levels[2].value;
                    hard = i_levels[2].hard;
                    pres = 1'b1;
                end
                dpp_pkg::PT_BIP44, dpp_pkg::PT_BIP49, dpp_pkg::PT_BIP54,
                dpp_pkg::PT_BIP74, dpp_pkg::PT_BIP84, dpp_pkg::PT_BIP86: begin
                    ok = i_count.is5 && i_levels[0].hard
                         && (i_levels[0].value == dpp_pkg::family_purpose(i_path_type))
                         && i_levels[1].hard && i_levels[2].hard && !i_levels[3].hard
                         && (i_levels[3].value <= 32'd1);
                    coin = i_levels[1].value;
                    acc  = i_levels[2].value;
                    chg  = i_levels[3].value;
                    idx  = i_levels[4].value;
                    hard = i_levels[4].hard;
                    pres = 1'b1;
                end
                dpp_pkg::PT_SLIP10: begin
                    ok   = i_count.ge1;
                    pres = 1'b1;
                end
                dpp_pkg::PT_CIP11, dpp_pkg::PT_CIP1852: begin
                    ok = i_count.is5
                         && i_levels[0].hard && (i_levels[0].value == cip_purpose)
                         && i_levels[1].hard && (i_levels[1].value == cip_coin)
                         && i_levels[2].hard && !i_levels[3].hard;
                    coin = cip_coin;
                    acc  = i_levels[2].value;
                    chg  = i_levels[3].value;
                    idx  = i_levels[4].value;
                    hard = i_levels[4].hard;
                    pres = 1'b1;
                end
                dpp_pkg::PT_ZIP32: begin
                    ok = (i_count.is3 || i_count.is4)
                         && i_levels[0].hard && (i_levels[0].value == dpp_pkg::PURPOSE_32)
                         && i_levels[1].hard && (i_levels[1].value == dpp_pkg::COIN_ZEC)
                         && i_levels[2].hard;
                    coin = dpp_pkg::COIN_ZEC;
                    acc  = i_levels[2].value;
                    if (i_count.is4) begin
                        idx  = i_levels[3].value;
                        hard = i_levels[3].hard;
                        pres = 1'b1;
                    end
                end
                default: begin
                    ok = 1'b0;
                end
            endcase
        end

        o_result.path_valid    = ok;
        o_result.coin_value    = ok ? coin : '0;
        o_result.account_value = ok ? acc  : '0;
        o_result.charge_value  = ok ? chg  : '0;
        o_result.leaf_index    = ok ? idx  : '0;
        o_result.leaf_hardened = ok & hard;
        o_result.leaf_present  = ok & pres;
    end

endmodule
